// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define CHK_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/scbu_pkg.sv =====
`timescale 1ns / 1ps

package scbu_pkg;

   localparam int PAIR_COUNT  = 4;
   localparam int PAIR_W      = 2;
   localparam int MS_PER_SEC  = 1000;
   localparam int MS_W        = 26;       // 65535 s in ms fits here
   localparam int COOL_W      = 15;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BEND_SNAPSHOTS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNFOLD_SNAPSHOTS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNFOLD_DELAY_SEC = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROGRESS_TO_SEC  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE_DIR      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_MIN_DEG    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_MAX_DEG    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_MS          = 3'd7;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_BEND    = 2'd1,
      ACT_UNFOLD  = 2'd2,
      ACT_IGNORED = 2'd3
   } act_type;

   typedef struct packed {
      logic [PAIR_W-1:0] pair;
      logic [31:0]       now_ms;
      logic              snapshot;
   } req_type;

   typedef struct packed {
      logic [PAIR_W-1:0] pair_out;
      logic              finger_bent;
      logic [7:0]        target_angle;
      logic [7:0]        bend_progress;
      logic [7:0]        unfold_progress;
      logic [COOL_W-1:0] cooldown_left_ms;
      logic              event_shown;
      act_type           action_shown;
   } rsp_type;

   typedef struct packed {
      logic        bent;
      logic [7:0]  bend_count;
      logic [7:0]  unfold_count;
      logic [31:0] last_bend_time;
      logic [31:0] last_unfold_time;
      logic [31:0] cooldown_until;
      logic        event_held;
      logic [31:0] event_until;
      act_type     action_held;
      logic [31:0] action_until;
   } pair_state_type;

endpackage

// ===== rtl/snapshot_count_bend_unfold_fsm.sv =====
`timescale 1ns / 1ps

// Words pass the input register, then the result register, before rsp_valid.
// Throughput: one word per cycle while rsp_stall is low, also back to back on the same
//   pair; per-pair state registers are written when the result register loads.
// Reset (synchronous): all pair state cleared (extended, counters zero), settings to
//   their defaults, both stages empty. No clearing pass; ready the cycle after reset.
module snapshot_count_bend_unfold_fsm (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  scbu_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output scbu_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [scbu_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [scbu_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import scbu_pkg::*;

   logic [7:0]      bend_snap_ff;
   logic [7:0]      unfold_snap_ff;
   logic [MS_W-1:0] delay_ms_ff;
   logic [MS_W-1:0] timeout_ms_ff;
   logic            reverse_ff;
   logic [7:0]      servo_min_ff;
   logic [7:0]      servo_max_ff;
   logic [15:0]     hold_ms_ff;
   logic [MS_W-1:0] csr_ms_in;

   pair_state_type  pair_ff [PAIR_COUNT];
   pair_state_type  pair_in;
   pair_state_type  cur;

   logic            s1_valid_ff;
   req_type         s1_data_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;
   rsp_type         rsp_in;

   logic            out_en;
   logic [31:0]     now;
   logic [31:0]     hold_until;
   logic [31:0]     cool_diff;
   logic [COOL_W-1:0] cool;
   logic            cool_fixed;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // seconds to ms once, at write time
   assign csr_ms_in = MS_W'(csr_wdata) * MS_W'(MS_PER_SEC);

   always_comb begin
      cur        = pair_ff[s1_data_ff.pair];
      pair_in    = cur;
      now        = s1_data_ff.now_ms;
      hold_until = now + 32'(hold_ms_ff);
      cool       = '0;
      cool_fixed = 1'b0;
      cool_diff  = '0;

      if (pair_in.event_held && now >= pair_in.event_until) begin
         pair_in.event_held  = 1'b0;
         pair_in.event_until = '0;
      end
      if (pair_in.action_held != ACT_NONE && now >= pair_in.action_until) begin
         pair_in.action_held  = ACT_NONE;
         pair_in.action_until = '0;
      end

      // stale progress
      if (!pair_in.bent) begin
         if (pair_in.bend_count != 8'd0 &&
             (now - pair_in.last_bend_time) >= 32'(timeout_ms_ff)) begin
            pair_in.bend_count     = '0;
            pair_in.last_bend_time = '0;
         end
      end else begin
         if (pair_in.unfold_count != 8'd0 &&
             (now - pair_in.last_unfold_time) >= 32'(timeout_ms_ff)) begin
            pair_in.unfold_count     = '0;
            pair_in.last_unfold_time = '0;
         end
      end

      if (s1_data_ff.snapshot) begin
         pair_in.event_held  = 1'b1;
         pair_in.event_until = hold_until;
         if (!pair_in.bent) begin
            if (pair_in.bend_count < bend_snap_ff)
               pair_in.bend_count = pair_in.bend_count + 8'd1;
            pair_in.last_bend_time = now;
            if (pair_in.bend_count >= bend_snap_ff) begin
               pair_in.bent             = 1'b1;
               pair_in.bend_count       = '0;
               pair_in.unfold_count     = '0;
               pair_in.last_bend_time   = '0;
               pair_in.last_unfold_time = '0;
               pair_in.cooldown_until   = now + 32'(delay_ms_ff);
               cool       = (delay_ms_ff > MS_W'(2**COOL_W - 1)) ?
                            {COOL_W{1'b1}} : delay_ms_ff[COOL_W-1:0];
               cool_fixed = 1'b1;
               pair_in.action_held  = ACT_BEND;
               pair_in.action_until = hold_until;
            end
         end else if (now < pair_in.cooldown_until) begin
            pair_in.action_held  = ACT_IGNORED;
            pair_in.action_until = hold_until;
         end else begin
            if (pair_in.unfold_count < unfold_snap_ff)
               pair_in.unfold_count = pair_in.unfold_count + 8'd1;
            pair_in.last_unfold_time = now;
            if (pair_in.unfold_count >= unfold_snap_ff) begin
               pair_in.bent             = 1'b0;
               pair_in.bend_count       = '0;
               pair_in.unfold_count     = '0;
               pair_in.last_bend_time   = '0;
               pair_in.last_unfold_time = '0;
               pair_in.action_held      = ACT_UNFOLD;
               pair_in.action_until     = hold_until;
            end
         end
      end

      if (!cool_fixed && now < pair_in.cooldown_until) begin
         cool_diff = pair_in.cooldown_until - now;
         cool = (|cool_diff[31:COOL_W]) ? {COOL_W{1'b1}} : cool_diff[COOL_W-1:0];
      end

      rsp_in.pair_out         = s1_data_ff.pair;
      rsp_in.finger_bent      = pair_in.bent;
      rsp_in.target_angle     = (pair_in.bent ^ reverse_ff) ? servo_min_ff : servo_max_ff;
      rsp_in.bend_progress    = pair_in.bend_count;
      rsp_in.unfold_progress  = pair_in.unfold_count;
      rsp_in.cooldown_left_ms = cool;
      rsp_in.event_shown      = pair_in.event_held;
      rsp_in.action_shown     = pair_in.action_held;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bend_snap_ff   <= 8'd3;
         unfold_snap_ff <= 8'd3;
         delay_ms_ff    <= MS_W'(MS_PER_SEC);
         timeout_ms_ff  <= MS_W'(5 * MS_PER_SEC);
         reverse_ff     <= 1'b0;
         servo_min_ff   <= 8'd0;
         servo_max_ff   <= 8'd180;
         hold_ms_ff     <= 16'd500;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < PAIR_COUNT; i++)
            pair_ff[i] <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BEND_SNAPSHOTS:   bend_snap_ff   <= csr_wdata[7:0];
               CSR_UNFOLD_SNAPSHOTS: unfold_snap_ff <= csr_wdata[7:0];
               CSR_UNFOLD_DELAY_SEC: delay_ms_ff    <= csr_ms_in;
               CSR_PROGRESS_TO_SEC:  timeout_ms_ff  <= csr_ms_in;
               CSR_REVERSE_DIR:      reverse_ff     <= csr_wdata[0];
               CSR_SERVO_MIN_DEG:    servo_min_ff   <= csr_wdata[7:0];
               CSR_SERVO_MAX_DEG:    servo_max_ff   <= csr_wdata[7:0];
               CSR_HOLD_MS:          hold_ms_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (!req_stall)
            s1_valid_ff <= req_valid;
         if (out_en)
            rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff && out_en)
            pair_ff[s1_data_ff.pair] <= pair_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall)
         s1_data_ff <= req_data;
      if (s1_valid_ff && out_en)
         rsp_data_ff <= rsp_in;
   end

endmodule

// ===== rtl/scbu_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scbu_chk (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input scbu_pkg::rsp_type rsp_data
);
   import scbu_pkg::*;

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result word changed")
   // bend and ignore indications only arise while bent; unfold leaves it extended
   `CHK_ALWAYS(a_act_bent, clock, reset, !rsp_valid || !(rsp_data.action_shown == ACT_BEND || rsp_data.action_shown == ACT_IGNORED) || rsp_data.finger_bent, "bend or ignored shown while extended")
   `CHK_ALWAYS(a_act_ext, clock, reset, !rsp_valid || rsp_data.action_shown != ACT_UNFOLD || !rsp_data.finger_bent, "unfold shown while bent")
   `CHK_ALWAYS(a_progress, clock, reset, !rsp_valid || (rsp_data.finger_bent ? rsp_data.bend_progress == 8'd0 : rsp_data.unfold_progress == 8'd0), "progress counter of the other state nonzero")

endmodule

bind snapshot_count_bend_unfold_fsm scbu_chk u_scbu_chk (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import scbu_pkg::*;

   // Mirrors the per-pair bend/unfold machine and holds the results it predicts.
   class finger_scoreboard;
      logic [7:0]     need_bend, need_unfold, min_deg, max_deg;
      logic [15:0]    delay_s, timeout_s, hold;
      logic           rev;
      pair_state_type st [PAIR_COUNT];
      rsp_type        pending [$];
      int             errors, checked, bends, unfolds, ignored;

      function new();
         need_bend   = 8'd3;
         need_unfold = 8'd3;
         delay_s     = 16'd1;
         timeout_s   = 16'd5;
         rev         = 1'b0;
         min_deg     = 8'd0;
         max_deg     = 8'd180;
         hold        = 16'd500;
         foreach (st[p]) st[p] = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_BEND_SNAPSHOTS:   need_bend   = val[7:0];
            CSR_UNFOLD_SNAPSHOTS: need_unfold = val[7:0];
            CSR_UNFOLD_DELAY_SEC: delay_s     = val;
            CSR_PROGRESS_TO_SEC:  timeout_s   = val;
            CSR_REVERSE_DIR:      rev         = val[0];
            CSR_SERVO_MIN_DEG:    min_deg     = val[7:0];
            CSR_SERVO_MAX_DEG:    max_deg     = val[7:0];
            CSR_HOLD_MS:          hold        = val;
            default: ;
         endcase
      endfunction

      function void clear_counts(inout pair_state_type s);
         s.bend_count       = '0;
         s.unfold_count     = '0;
         s.last_bend_time   = '0;
         s.last_unfold_time = '0;
      endfunction

      function void note_word(req_type w);
         pair_state_type s;
         logic [31:0]    now, span, delay, cool;
         bit             bend_step;
         rsp_type        r;
         s         = st[w.pair];
         now       = w.now_ms;
         span      = {16'd0, timeout_s} * MS_PER_SEC;
         cool      = '0;
         bend_step = 1'b0;
         // held indications expire on a plain (non-wrapping) compare
         if (s.event_held && now >= s.event_until) begin
            s.event_held  = 1'b0;
            s.event_until = '0;
         end
         if (s.action_held != ACT_NONE && now >= s.action_until) begin
            s.action_held  = ACT_NONE;
            s.action_until = '0;
         end
         if (!s.bent) begin
            if (s.bend_count != 0 && 32'(now - s.last_bend_time) >= span) begin
               s.bend_count     = '0;
               s.last_bend_time = '0;
            end
         end else if (s.unfold_count != 0 && 32'(now - s.last_unfold_time) >= span) begin
            s.unfold_count     = '0;
            s.last_unfold_time = '0;
         end
         if (w.snapshot) begin
            s.event_held  = 1'b1;
            s.event_until = now + {16'd0, hold};
            if (!s.bent) begin
               if (s.bend_count < need_bend) s.bend_count++;
               s.last_bend_time = now;
               if (s.bend_count >= need_bend) begin
                  delay = {16'd0, delay_s} * MS_PER_SEC;
                  s.bent = 1'b1;
                  clear_counts(s);
                  s.cooldown_until = now + delay;
                  cool             = delay;
                  bend_step        = 1'b1;
                  s.action_held    = ACT_BEND;
                  s.action_until   = now + {16'd0, hold};
                  bends++;
               end
            end else if (now < s.cooldown_until) begin
               s.action_held  = ACT_IGNORED;
               s.action_until = now + {16'd0, hold};
               ignored++;
            end else begin
               if (s.unfold_count < need_unfold) s.unfold_count++;
               s.last_unfold_time = now;
               if (s.unfold_count >= need_unfold) begin
                  s.bent = 1'b0;
                  clear_counts(s);
                  s.action_held  = ACT_UNFOLD;
                  s.action_until = now + {16'd0, hold};
                  unfolds++;
               end
            end
         end
         if (!bend_step)
            cool = (now < s.cooldown_until) ? s.cooldown_until - now : '0;
         r.pair_out         = w.pair;
         r.finger_bent      = s.bent;
         r.target_angle     = (s.bent ^ rev) ? min_deg : max_deg;
         r.bend_progress    = s.bend_count;
         r.unfold_progress  = s.unfold_count;
         r.cooldown_left_ms = (cool > 32'h7FFF) ? '1 : cool[COOL_W-1:0];
         r.event_shown      = s.event_held;
         r.action_shown     = s.action_held;
         st[w.pair] = s;
         pending.push_back(r);
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         errors++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      endfunction

      function void check_word(rsp_type got);
         rsp_type exp;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word %h", $time, got);
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (got.pair_out !== exp.pair_out)
            report("pair_out", exp.pair_out, got.pair_out);
         if (got.finger_bent !== exp.finger_bent)
            report("finger_bent", exp.finger_bent, got.finger_bent);
         if (got.target_angle !== exp.target_angle)
            report("target_angle", exp.target_angle, got.target_angle);
         if (got.bend_progress !== exp.bend_progress)
            report("bend_progress", exp.bend_progress, got.bend_progress);
         if (got.unfold_progress !== exp.unfold_progress)
            report("unfold_progress", exp.unfold_progress, got.unfold_progress);
         if (got.cooldown_left_ms !== exp.cooldown_left_ms)
            report("cooldown_left_ms", exp.cooldown_left_ms, got.cooldown_left_ms);
         if (got.event_shown !== exp.event_shown)
            report("event_shown", exp.event_shown, got.event_shown);
         if (got.action_shown !== exp.action_shown)
            report("action_shown", exp.action_shown, got.action_shown);
      endfunction
   endclass

   typedef struct {
      logic [7:0]  bend_n;
      logic [7:0]  unfold_n;
      logic [15:0] delay_s;
      logic [15:0] timeout_s;
      logic        rev;
      logic [7:0]  min_deg;
      logic [7:0]  max_deg;
      logic [15:0] hold;
      int          words;
      int          pair_hi;
      int          snap_pct;
      int          step_ms;
      bit          calm;        // forward time only, no jumps
      int          idle_send;
      int          idle_recv;
   } setting_plan;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   finger_scoreboard board = new();
   int                      send_idle_pct = 0;
   int                      stall_pct = 0;
   int                      words_sent = 0;
   logic [31:0]             clock_ms = '0;
   setting_plan             plans [6];

   snapshot_count_bend_unfold_fsm dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_word(rsp_data);
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_word(input logic [PAIR_W-1:0] pair, input logic [31:0] now,
                            input logic snap);
      req_type w;
      w.pair     = pair;
      w.now_ms   = now;
      w.snapshot = snap;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      board.note_word(w);
      words_sent++;
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Time mostly moves forward in small steps; the rest crosses hold, cooldown
   // and timeout windows, steps back, or jumps anywhere including near the wrap.
   task automatic send_random(input setting_plan pl);
      int unsigned k;
      k = $urandom_range(99);
      if (k < 70)
         clock_ms = clock_ms + 32'($urandom_range(pl.step_ms));
      else if (k < 90 || pl.calm)
         clock_ms = clock_ms + 32'($urandom_range(pl.step_ms * 16));
      else if (k < 95)
         clock_ms = clock_ms - 32'($urandom_range(pl.step_ms));
      else if (k < 98)
         clock_ms = $urandom();
      else
         clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(pl.step_ms * 4));
      send_word(PAIR_W'($urandom_range(pl.pair_hi)), clock_ms,
                $urandom_range(99) < pl.snap_pct);
   endtask

   initial begin
      setting_plan pl;
      plans[0] = '{8'd2, 8'd2, 16'd1, 16'd2, 1'b0, 8'd15, 8'd165, 16'd300,
                   200, 3, 60, 500, 1'b0, 11, 49};
      // zero thresholds, delay, timeout and hold: every counted snapshot flips the finger
      plans[1] = '{8'd0, 8'd0, 16'd0, 16'd0, 1'b1, 8'd0, 8'd180, 16'd0,
                   200, 3, 50, 50, 1'b0, 11, 49};
      plans[2] = '{8'd4, 8'd3, 16'd2, 16'd3, 1'b1, 8'd30, 8'd150, 16'd1000,
                   200, 1, 70, 700, 1'b0, 49, 11};
      // top bend threshold and delays on one pair; cooldown readout saturates
      plans[3] = '{8'd255, 8'd1, 16'd65535, 16'd65535, 1'b0, 8'd180, 8'd0, 16'd65535,
                   350, 0, 95, 200, 1'b1, 49, 11};
      // endpoints above 180, long unfold run inside a short timeout
      plans[4] = '{8'd1, 8'd255, 16'd0, 16'd1, 1'b1, 8'd200, 8'd255, 16'd700,
                   350, 0, 95, 20, 1'b1, 0, 0};
      plans[5] = '{8'd3, 8'd3, 16'd1, 16'd5, 1'b0, 8'd0, 8'd180, 16'd500,
                   200, 3, 60, 600, 1'b0, 0, 0};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words at the reset settings
      send_idle_pct = 11;
      stall_pct     = 49;
      send_word(2'd0, 32'd0, 1'b0);
      send_word(2'd0, 32'd100, 1'b1);
      send_word(2'd0, 32'd200, 1'b1);
      send_word(2'd0, 32'd300, 1'b1);          // bend, cooldown starts
      send_word(2'd0, 32'd500, 1'b1);          // inside cooldown
      send_word(2'd0, 32'd900, 1'b0);
      send_word(2'd0, 32'd1400, 1'b1);
      send_word(2'd0, 32'd7000, 1'b0);         // stale unfold count clears
      send_word(2'd0, 32'd7100, 1'b1);
      send_word(2'd0, 32'd7200, 1'b1);
      send_word(2'd0, 32'd7300, 1'b1);         // unfold
      send_word(2'd0, 32'd9000, 1'b0);
      send_word(2'd3, 32'hFFFF_FE00, 1'b1);
      send_word(2'd3, 32'hFFFF_FF00, 1'b1);
      send_word(2'd3, 32'hFFFF_FFFF, 1'b1);    // bend with cooldown end past the wrap
      send_word(2'd3, 32'h0000_0010, 1'b1);
      send_word(2'd3, 32'h0000_0400, 1'b1);
      send_word(2'd1, 32'h5555_AAAA, 1'b0);
      send_word(2'd2, 32'hAAAA_5555, 1'b1);
      send_word(2'd1, 32'hAAAA_5555, 1'b1);

      foreach (plans[i]) begin
         pl = plans[i];
         drain();
         write_setting(CSR_BEND_SNAPSHOTS,   {8'd0, pl.bend_n});
         write_setting(CSR_UNFOLD_SNAPSHOTS, {8'd0, pl.unfold_n});
         write_setting(CSR_UNFOLD_DELAY_SEC, pl.delay_s);
         write_setting(CSR_PROGRESS_TO_SEC,  pl.timeout_s);
         write_setting(CSR_REVERSE_DIR,      {15'd0, pl.rev});
         write_setting(CSR_SERVO_MIN_DEG,    {8'd0, pl.min_deg});
         write_setting(CSR_SERVO_MAX_DEG,    {8'd0, pl.max_deg});
         write_setting(CSR_HOLD_MS,          pl.hold);
         send_idle_pct = pl.idle_send;
         stall_pct     = pl.idle_recv;
         repeat (pl.words) send_random(pl);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      drain();
      repeat (4) @(posedge clock);
      $display("Sent %0d words over %0d setting phases, %0d results checked.",
               words_sent, $size(plans), board.checked);
      $display("Saw %0d bends, %0d unfolds and %0d snapshots ignored in cooldown.",
               board.bends, board.unfolds, board.ignored);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
